// ----- design/box_downsample_2x2_assert.svh -----
// Assertion macros for the verification-side checker of box_downsample_2x2.
// Depends on nothing; include by bare file name.
`ifndef BOX_DOWNSAMPLE_2X2_ASSERT_SVH
`define BOX_DOWNSAMPLE_2X2_ASSERT_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define BDS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication: cons must hold in the cycle after ante.
`define BDS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ----- design/bds_pkg.sv -----
// Package for box_downsample_2x2: request/response payload types, line store
// entry type and register index codes. Depends on nothing.
`default_nettype none

package bds_pkg;

   localparam int CHANNELS         = 4;
   localparam int PIXEL_BITS       = 8;
   localparam int PAIR_BITS        = PIXEL_BITS + 1;
   localparam int IMAGE_WIDTH_BITS = 13;
   localparam int CHANNEL_CNT_BITS = 3;
   localparam int CSR_DATA_BITS    = 13;

   localparam logic [CHANNEL_CNT_BITS-1:0] CHANNEL_COUNT_RGB  = 3'd3;
   localparam logic [CHANNEL_CNT_BITS-1:0] CHANNEL_COUNT_RGBA = 3'd4;
   localparam logic [IMAGE_WIDTH_BITS-1:0] IMAGE_WIDTH_RESET  = 13'd2;

   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH   = 1'b0,
      CSR_CHANNEL_COUNT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] in_c0;
      logic [PIXEL_BITS-1:0] in_c1;
      logic [PIXEL_BITS-1:0] in_c2;
      logic [PIXEL_BITS-1:0] in_c3;
   } req_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] out_c0;
      logic [PIXEL_BITS-1:0] out_c1;
      logic [PIXEL_BITS-1:0] out_c2;
      logic [PIXEL_BITS-1:0] out_c3;
      logic                  row_end;
   } rsp_type;

   typedef logic [CHANNELS-1:0][PIXEL_BITS-1:0] pixel_type;
   typedef logic [CHANNELS-1:0][PAIR_BITS-1:0]  pair_type;

endpackage

`default_nettype wire

// ----- design/box_downsample_2x2.sv -----
// 2x2 box-filter downsampler for a raster pixel stream, up to four channels.
// Path: stage 1 register, then result register; one result per 2x2 block, on its last pixel.
// Throughput: one request per cycle while the result register is not stalled; the
// line store has one memory read port and one write port for pair sums.
// Reset: synchronous, active high; clears row position and pipeline valids,
// restores image_width = 2 and channel_count = 4. Line store is not cleared.
`default_nettype none

module box_downsample_2x2 #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // source pixel requests
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  bds_pkg::req_type                        req_data,
   // downsampled pixel results
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output bds_pkg::rsp_type                        rsp_data,
   // register writes
   input  logic                                    csr_we,
   input  bds_pkg::csr_index_type                  csr_index,
   input  logic [bds_pkg::CSR_DATA_BITS-1:0]       csr_wdata
);
   import bds_pkg::*;

   // Line store holds one pair sum per horizontal pair of the widest row.
   localparam int DEPTH     = MAX_WIDTH / 2;
   localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW        = $clog2(MAX_WIDTH);
   localparam int WW        = (CW + 1 > IMAGE_WIDTH_BITS) ? CW + 1 : IMAGE_WIDTH_BITS;
   localparam int MAXW_EVEN = MAX_WIDTH - (MAX_WIDTH % 2);

   // Configuration registers
   logic [IMAGE_WIDTH_BITS-1:0] image_width_ff;
   logic [CHANNEL_CNT_BITS-1:0] channel_count_ff;

   // Row position
   logic [CW-1:0] column_index_ff, column_index_in;
   logic          odd_row_ff, odd_row_in;

   // Stage 1: registered request plus line store read data
   logic            s1_valid_ff, s1_valid_in;
   pixel_type       s1_px_ff;
   logic            s1_odd_col_ff;
   logic            s1_odd_row_ff;
   logic            s1_last_ff;
   logic            s1_three_ff;
   logic [AW-1:0]   s1_idx_ff;
   pair_type        line_rd_ff;
   pair_type        pair_sum_ff;

   // Result register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff;

   // Line store
   pair_type        line_mem [DEPTH];

   logic            accept;
   logic            three;
   logic [WW-1:0]   width_even;
   logic [WW-1:0]   width_eff;
   logic [WW-1:0]   col_cur;
   logic [WW-1:0]   col_next;
   logic            col_last;
   logic [AW-1:0]   rd_idx;
   pixel_type       px_in;
   logic            s1_produce;
   logic            s1_go;
   pair_type        pair_now;
   rsp_type         rsp_next;

   // ------------------------------------------------------------------
   // Register writes
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff   <= IMAGE_WIDTH_RESET;
         channel_count_ff <= CHANNEL_COUNT_RGBA;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:   image_width_ff   <= csr_wdata[IMAGE_WIDTH_BITS-1:0];
            CSR_CHANNEL_COUNT: channel_count_ff <= csr_wdata[CHANNEL_CNT_BITS-1:0];
            default:           ;
         endcase
      end
   end

   assign three = (channel_count_ff == CHANNEL_COUNT_RGB);

   // ------------------------------------------------------------------
   // Effective width: round down to even, clamp to 2..largest even width
   // ------------------------------------------------------------------
   always_comb begin
      width_even = WW'({image_width_ff[IMAGE_WIDTH_BITS-1:1], 1'b0});
      if (width_even < WW'(2)) begin
         width_eff = WW'(2);
      end else if (width_even > WW'(MAXW_EVEN)) begin
         width_eff = WW'(MAXW_EVEN);
      end else begin
         width_eff = width_even;
      end
   end

   // ------------------------------------------------------------------
   // Stage 0: position of the incoming pixel and row bookkeeping
   // ------------------------------------------------------------------
   always_comb begin
      // A column past the current width restarts the row at column 0.
      col_cur = (WW'(column_index_ff) >= width_eff) ? '0 : WW'(column_index_ff);
      col_next = col_cur + WW'(1);
      col_last = (col_cur == width_eff - WW'(1));
      rd_idx   = AW'(col_cur >> 1);

      if (col_next >= width_eff) begin
         column_index_in = '0;
         odd_row_in      = ~odd_row_ff;
      end else begin
         column_index_in = CW'(col_next);
         odd_row_in      = odd_row_ff;
      end

      px_in[0] = req_data.in_c0;
      px_in[1] = req_data.in_c1;
      px_in[2] = req_data.in_c2;
      // drop the fourth channel in RGB mode
      px_in[3] = three ? '0 : req_data.in_c3;
   end

   // ------------------------------------------------------------------
   // Flow control: stage 1 advances unless its result would land on a
   // full, stalled result register.
   // ------------------------------------------------------------------
   assign s1_produce = s1_valid_ff && s1_odd_col_ff && s1_odd_row_ff;
   assign s1_go      = s1_valid_ff && (!s1_produce || !rsp_valid_ff || rsp_ready);
   assign req_ready  = !reset && (!s1_valid_ff || s1_go);
   assign accept     = req_valid && req_ready;

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_index_ff <= '0;
         odd_row_ff      <= 1'b0;
         s1_valid_ff     <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (accept) begin
            column_index_ff <= column_index_in;
            odd_row_ff      <= odd_row_in;
         end
      end
   end

   // Capture the request payload and its position.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff      <= px_in;
         s1_odd_col_ff <= col_cur[0];
         s1_odd_row_ff <= odd_row_ff;
         s1_last_ff    <= col_last;
         s1_three_ff   <= three;
         s1_idx_ff     <= rd_idx;
      end
   end

   // ------------------------------------------------------------------
   // Line store: read at acceptance of an odd-column pixel, write when an even row's pair closes.
   // A read never needs the entry written in the same cycle: that entry is
   // read back only one full row later.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (accept && col_cur[0]) begin
         line_rd_ff <= line_mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_odd_col_ff && !s1_odd_row_ff) begin
         line_mem[s1_idx_ff] <= pair_now;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: pair sum and 2x2 average
   // ------------------------------------------------------------------
   always_comb begin
      logic [PAIR_BITS:0] total [CHANNELS];
      logic [PIXEL_BITS-1:0] avg [CHANNELS];
      for (int q = 0; q < CHANNELS; q++) begin
         pair_now[q] = PAIR_BITS'(pair_sum_ff[q]) + PAIR_BITS'(s1_px_ff[q]);
         total[q]    = (PAIR_BITS+1)'(line_rd_ff[q]) + (PAIR_BITS+1)'(pair_now[q]);
         avg[q]      = total[q][PAIR_BITS:2];
      end
      rsp_next.out_c0  = avg[0];
      rsp_next.out_c1  = avg[1];
      rsp_next.out_c2  = avg[2];
      rsp_next.out_c3  = s1_three_ff ? '0 : avg[3];
      rsp_next.row_end = s1_last_ff;
   end

   // Hold the even-column pixel until its partner arrives.
   always_ff @(posedge clock) begin
      if (s1_go && !s1_odd_col_ff) begin
         for (int q = 0; q < CHANNELS; q++) begin
            pair_sum_ff[q] <= PAIR_BITS'(s1_px_ff[q]);
         end
      end
   end

   // ------------------------------------------------------------------
   // Result register
   // ------------------------------------------------------------------
   always_comb begin
      if (s1_go && s1_produce) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_produce) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- design/bds_checker.sv -----
// Port-level checker for box_downsample_2x2, attached by bind below.
// Depends on bds_pkg and box_downsample_2x2_assert.svh.
`default_nettype none

`include "box_downsample_2x2_assert.svh"

module bds_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input bds_pkg::rsp_type rsp_data
);
   import bds_pkg::*;

   // stalled result stays offered
   `BDS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   // stalled result keeps its payload
   `BDS_ASSERT_NXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_data))
   // reset empties the result register
   `BDS_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)
   // a fresh result traces back to an accepted request, through stage 1 and the result register
   `BDS_ASSERT_IMP(a_rsp_source, clock, reset, $rose(rsp_valid), $past(req_valid && req_ready, 2))

endmodule

bind box_downsample_2x2 bds_checker u_bds_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
